// ===== hdl/fresnel_conductor_rgb_assert.svh =====
// Assertion macros used by the checker file of the Fresnel conductor block.
`ifndef FRESNEL_CONDUCTOR_RGB_ASSERT_SVH
`define FRESNEL_CONDUCTOR_RGB_ASSERT_SVH

// Same-cycle implication, clocked on clock, off while reset is high.
`define FCR_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fcr assertion failed");

// Next-cycle implication, clocked on clock, off while reset is high.
`define FCR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fcr assertion failed");

`endif

// ===== hdl/fcr_pkg.sv =====
// Widths, constants and sideband types of the Fresnel conductor pipeline.
package fcr_pkg;

   localparam int FRAC    = 20;
   localparam int IO_W    = 16;
   localparam int REFL_W  = 16;
   localparam int FIELDS  = 3;
   localparam int REQ_W   = IO_W * (1 + 2 * FIELDS);
   localparam int RSP_W   = REFL_W * FIELDS;
   localparam int C14_W   = 15;
   localparam int Q20_W   = FRAC + 1;
   localparam int SQ_W    = 2 * IO_W - 4;
   localparam int T0_W    = SQ_W + 2;
   localparam int RAD1_W  = 2 * T0_W;
   localparam int A2B2_W  = RAD1_W / 2;
   localparam int A2_W    = A2B2_W - 1;
   localparam int RAD2_W  = A2_W + FRAC + 1;
   localparam int A_W     = RAD2_W / 2;
   localparam int T1_W    = A2B2_W + 1;
   localparam int T2_W    = 27;
   localparam int T3_W    = 31;
   localparam int T4_W    = 27;
   localparam int DEN_W   = 32;
   localparam int QUO_W   = FRAC + 1;
   localparam int RS_W    = QUO_W + 1;
   localparam int NUM1_W  = T1_W + FRAC;
   localparam int NUM2_W  = QUO_W + T3_W;

   localparam logic [C14_W-1:0] C14_ONE   = 15'd16384;
   localparam logic [Q20_W-1:0] ONE_Q20   = 21'h100000;
   localparam logic [REFL_W-1:0] REFL_ONE = 16'd32768;

   // Stages: 3 front, first root, 1 between roots, second root, 3 before the first
   // divider, first divider, 2 between dividers, second divider, 1 final.
   localparam int LANE_LAT = 3 + RAD1_W / 2 + 1 + RAD2_W / 2 + 3 + QUO_W + 2 + QUO_W + 1;

   typedef struct packed {
      logic signed [T0_W-1:0] t0;
      logic [Q20_W-1:0]       cos2;
      logic [Q20_W-1:0]       sin2;
      logic [Q20_W-1:0]       cf;
   } sq1_side_type;

   typedef struct packed {
      logic [A2B2_W-1:0] a2b2;
      logic [Q20_W-1:0]  cos2;
      logic [Q20_W-1:0]  sin2;
      logic [Q20_W-1:0]  cf;
   } sq2_side_type;

   typedef struct packed {
      logic            neg;
      logic [T3_W-1:0] t3;
      logic [T4_W-1:0] t4;
   } div1_side_type;

   typedef struct packed {
      logic                   neg;
      logic signed [RS_W-1:0] rs;
   } div2_side_type;

endpackage

// ===== hdl/fcr_sqrt_pipe.sv =====
// Pipelined floor square root, one root bit per stage, with a sideband carried alongside.
module fcr_sqrt_pipe #(
   parameter int RAD_W  = 60,
   parameter int SIDE_W = 8
) (
   input  logic                clock,
   input  logic                en,
   input  logic [RAD_W-1:0]    rad_in,
   input  logic [SIDE_W-1:0]   side_in,
   output logic [RAD_W/2-1:0]  root_out,
   output logic [SIDE_W-1:0]   side_out
);

   localparam int N  = RAD_W / 2;
   localparam int RW = RAD_W + 1;

   logic [RW-1:0]     rem_d  [0:N-1];
   logic [N-1:0]      root_d [0:N];
   logic [SIDE_W-1:0] side_d [0:N];

   assign rem_d[0]  = RW'(rad_in);
   assign root_d[0] = '0;
   assign side_d[0] = side_in;

   for (genvar s = 0; s < N; s++) begin : g_stage
      localparam int BIT = N - 1 - s;
      logic [RW-1:0]     trial;
      logic              take;
      logic [N-1:0]      root_ff;
      logic [SIDE_W-1:0] side_ff;

      // trial = (2r + 2^BIT) * 2^BIT, the growth of r^2 when this bit is set
      assign trial = (RW'({root_d[s], 1'b0}) | (RW'(1) << BIT)) << BIT;
      assign take  = rem_d[s] >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff <= take ? (root_d[s] | (N'(1) << BIT)) : root_d[s];
            side_ff <= side_d[s];
         end
      end

      assign root_d[s+1] = root_ff;
      assign side_d[s+1] = side_ff;

      if (s < N - 1) begin : g_rem
         logic [RW-1:0] rem_ff;
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff <= take ? (rem_d[s] - trial) : rem_d[s];
            end
         end
         assign rem_d[s+1] = rem_ff;
      end
   end

   assign root_out = root_d[N];
   assign side_out = side_d[N];

endmodule

// ===== hdl/fcr_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a sideband carried alongside.
module fcr_div_pipe #(
   parameter int NUM_W  = 51,
   parameter int DEN_W  = 32,
   parameter int Q_W    = 21,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              en,
   input  logic [NUM_W-1:0]  num_in,
   input  logic [DEN_W-1:0]  den_in,
   input  logic [SIDE_W-1:0] side_in,
   output logic [Q_W-1:0]    quo_out,
   output logic [SIDE_W-1:0] side_out
);

   localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

   logic [W-1:0]      rem_d  [0:Q_W-1];
   logic [DEN_W-1:0]  den_d  [0:Q_W-1];
   logic [Q_W-1:0]    quo_d  [0:Q_W];
   logic [SIDE_W-1:0] side_d [0:Q_W];

   assign rem_d[0]  = W'(num_in);
   assign den_d[0]  = den_in;
   assign quo_d[0]  = '0;
   assign side_d[0] = side_in;

   for (genvar s = 0; s < Q_W; s++) begin : g_stage
      localparam int BIT = Q_W - 1 - s;
      logic [W-1:0]      sub;
      logic              take;
      logic [Q_W-1:0]    quo_ff;
      logic [SIDE_W-1:0] side_ff;

      assign sub  = W'(den_d[s]) << BIT;
      assign take = rem_d[s] >= sub;

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff  <= take ? (quo_d[s] | (Q_W'(1) << BIT)) : quo_d[s];
            side_ff <= side_d[s];
         end
      end

      assign quo_d[s+1]  = quo_ff;
      assign side_d[s+1] = side_ff;

      if (s < Q_W - 1) begin : g_rem
         logic [W-1:0]     rem_ff;
         logic [DEN_W-1:0] den_ff;
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff <= take ? (rem_d[s] - sub) : rem_d[s];
               den_ff <= den_d[s];
            end
         end
         assign rem_d[s+1] = rem_ff;
         assign den_d[s+1] = den_ff;
      end
   end

   assign quo_out  = quo_d[Q_W];
   assign side_out = side_d[Q_W];

endmodule

// ===== hdl/fcr_lane.sv =====
// One colour lane: conductor Fresnel reflectance of one channel, fully pipelined.
module fcr_lane
   import fcr_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [C14_W-1:0]  c14,
   input  logic [IO_W-1:0]   eta,
   input  logic [IO_W-1:0]   k,
   output logic [REFL_W-1:0] refl
);

   // stage 1: squares
   logic [2*C14_W-1:0] csq;
   logic [2*IO_W-1:0]  esq;
   logic [2*IO_W-1:0]  ksq;
   logic [Q20_W-1:0]   cos2_s1_ff, cf_s1_ff;
   logic [SQ_W-1:0]    eta2_s1_ff, k2_s1_ff;

   assign csq = c14 * c14;
   assign esq = eta * eta;
   assign ksq = k * k;

   always_ff @(posedge clock) begin
      if (en) begin
         cos2_s1_ff <= Q20_W'(csq >> 8);
         cf_s1_ff   <= Q20_W'({c14, 6'b000000});
         eta2_s1_ff <= SQ_W'(esq >> 4);
         k2_s1_ff   <= SQ_W'(ksq >> 4);
      end
   end

   // stage 2: t0 and eta2*k2
   logic [Q20_W-1:0]       sin2_in;
   logic signed [T0_W-1:0] t0_in;
   logic signed [T0_W-1:0] t0_s2_ff;
   logic [2*SQ_W-1:0]      ek_s2_ff;
   logic [Q20_W-1:0]       cos2_s2_ff, sin2_s2_ff, cf_s2_ff;

   assign sin2_in = ONE_Q20 - cos2_s1_ff;
   assign t0_in   = $signed(T0_W'(eta2_s1_ff)) - $signed(T0_W'(k2_s1_ff))
                    - $signed(T0_W'(sin2_in));

   always_ff @(posedge clock) begin
      if (en) begin
         t0_s2_ff   <= t0_in;
         ek_s2_ff   <= eta2_s1_ff * k2_s1_ff;
         cos2_s2_ff <= cos2_s1_ff;
         sin2_s2_ff <= sin2_in;
         cf_s2_ff   <= cf_s1_ff;
      end
   end

   // stage 3: radicand t0^2 + 4*eta2*k2
   logic signed [2*T0_W-1:0] t0sq;
   logic [RAD1_W-1:0]        rad1_s3_ff;
   sq1_side_type             sq1_s3_ff, sq1_out;
   logic [A2B2_W-1:0]        a2b2;

   assign t0sq = t0_s2_ff * t0_s2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rad1_s3_ff     <= RAD1_W'($unsigned(t0sq)) + RAD1_W'({ek_s2_ff, 2'b00});
         sq1_s3_ff.t0   <= t0_s2_ff;
         sq1_s3_ff.cos2 <= cos2_s2_ff;
         sq1_s3_ff.sin2 <= sin2_s2_ff;
         sq1_s3_ff.cf   <= cf_s2_ff;
      end
   end

   fcr_sqrt_pipe #(
      .RAD_W  (RAD1_W),
      .SIDE_W ($bits(sq1_side_type))
   ) u_sqrt_a2b2 (
      .clock    (clock),
      .en       (en),
      .rad_in   (rad1_s3_ff),
      .side_in  (sq1_s3_ff),
      .root_out (a2b2),
      .side_out (sq1_out)
   );

   // stage 4: a^2 = (a2b2 + t0) / 2, floored at zero
   logic signed [A2B2_W:0] half_in;
   logic [A2_W-1:0]        a2_in;
   logic [RAD2_W-1:0]      rad2_s4_ff;
   sq2_side_type           sq2_s4_ff, sq2_out;
   logic [A_W-1:0]         a;

   assign half_in = $signed({1'b0, a2b2}) + (A2B2_W+1)'(sq1_out.t0);
   assign a2_in   = (half_in > 0) ? half_in[A2B2_W-1:1] : '0;

   always_ff @(posedge clock) begin
      if (en) begin
         rad2_s4_ff     <= RAD2_W'({a2_in, {FRAC{1'b0}}});
         sq2_s4_ff.a2b2 <= a2b2;
         sq2_s4_ff.cos2 <= sq1_out.cos2;
         sq2_s4_ff.sin2 <= sq1_out.sin2;
         sq2_s4_ff.cf   <= sq1_out.cf;
      end
   end

   fcr_sqrt_pipe #(
      .RAD_W  (RAD2_W),
      .SIDE_W ($bits(sq2_side_type))
   ) u_sqrt_a (
      .clock    (clock),
      .en       (en),
      .rad_in   (rad2_s4_ff),
      .side_in  (sq2_s4_ff),
      .root_out (a),
      .side_out (sq2_out)
   );

   // stage 5: products feeding t2 and t3
   logic [A_W+Q20_W-1:0]    p_s5_ff;
   logic [Q20_W+A2B2_W-1:0] q1_s5_ff;
   logic [2*Q20_W-1:0]      ss_s5_ff;
   logic [T1_W-1:0]         t1_s5_ff;
   logic [Q20_W-1:0]        sin2_s5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_s5_ff    <= a * sq2_out.cf;
         q1_s5_ff   <= sq2_out.cos2 * sq2_out.a2b2;
         ss_s5_ff   <= sq2_out.sin2 * sq2_out.sin2;
         t1_s5_ff   <= T1_W'(sq2_out.a2b2) + T1_W'(sq2_out.cos2);
         sin2_s5_ff <= sq2_out.sin2;
      end
   end

   // stage 6: t2, t3
   logic [T2_W-1:0]  t2_s6_ff;
   logic [T3_W-1:0]  t3_s6_ff;
   logic [T1_W-1:0]  t1_s6_ff;
   logic [Q20_W-1:0] sin2_s6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         t2_s6_ff   <= T2_W'(p_s5_ff >> FRAC) << 1;
         t3_s6_ff   <= T3_W'((q1_s5_ff + (Q20_W+A2B2_W)'(ss_s5_ff)) >> FRAC);
         t1_s6_ff   <= t1_s5_ff;
         sin2_s6_ff <= sin2_s5_ff;
      end
   end

   // stage 7: t4, s-term numerator magnitude and floored denominator
   logic [T2_W+Q20_W-1:0] tm;
   logic                  sneg;
   logic [T1_W-1:0]       smag;
   logic [DEN_W-1:0]      dens_raw, dens_in;
   logic [NUM1_W-1:0]     num1_s7_ff;
   logic [DEN_W-1:0]      dens_s7_ff;
   div1_side_type         d1_s7_ff, d1_out;
   logic [QUO_W-1:0]      quo1;

   assign tm       = t2_s6_ff * sin2_s6_ff;
   assign sneg     = t1_s6_ff < T1_W'(t2_s6_ff);
   assign smag     = sneg ? (T1_W'(t2_s6_ff) - t1_s6_ff) : (t1_s6_ff - T1_W'(t2_s6_ff));
   assign dens_raw = DEN_W'(t1_s6_ff) + DEN_W'(t2_s6_ff);
   assign dens_in  = (dens_raw == '0) ? DEN_W'(1) : dens_raw;

   always_ff @(posedge clock) begin
      if (en) begin
         num1_s7_ff   <= NUM1_W'({smag, {FRAC{1'b0}}});
         dens_s7_ff   <= dens_in;
         d1_s7_ff.neg <= sneg;
         d1_s7_ff.t3  <= t3_s6_ff;
         d1_s7_ff.t4  <= T4_W'(tm >> FRAC);
      end
   end

   fcr_div_pipe #(
      .NUM_W  (NUM1_W),
      .DEN_W  (DEN_W),
      .Q_W    (QUO_W),
      .SIDE_W ($bits(div1_side_type))
   ) u_div_rs (
      .clock    (clock),
      .en       (en),
      .num_in   (num1_s7_ff),
      .den_in   (dens_s7_ff),
      .side_in  (d1_s7_ff),
      .quo_out  (quo1),
      .side_out (d1_out)
   );

   // stage 8: signed Rs, p-term difference and floored denominator
   logic signed [RS_W-1:0] rs_in, rs_s8_ff;
   logic                   dneg_in, dneg_s8_ff;
   logic [T3_W-1:0]        dmag_in, dmag_s8_ff;
   logic [DEN_W-1:0]       denp_raw, denp_in, denp_s8_ff;

   assign rs_in    = d1_out.neg ? -$signed({1'b0, quo1}) : $signed({1'b0, quo1});
   assign dneg_in  = d1_out.t3 < T3_W'(d1_out.t4);
   assign dmag_in  = dneg_in ? (T3_W'(d1_out.t4) - d1_out.t3) : (d1_out.t3 - T3_W'(d1_out.t4));
   assign denp_raw = DEN_W'(d1_out.t3) + DEN_W'(d1_out.t4);
   assign denp_in  = (denp_raw == '0) ? DEN_W'(1) : denp_raw;

   always_ff @(posedge clock) begin
      if (en) begin
         rs_s8_ff   <= rs_in;
         dneg_s8_ff <= dneg_in;
         dmag_s8_ff <= dmag_in;
         denp_s8_ff <= denp_in;
      end
   end

   // stage 9: |Rs| * |t3 - t4|
   logic [QUO_W-1:0]  rsmag;
   logic [NUM2_W-1:0] num2_s9_ff;
   logic [DEN_W-1:0]  denp_s9_ff;
   div2_side_type     d2_s9_ff, d2_out;
   logic [QUO_W-1:0]  quo2;

   assign rsmag = rs_s8_ff[RS_W-1] ? QUO_W'(-rs_s8_ff) : QUO_W'(rs_s8_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         num2_s9_ff   <= rsmag * dmag_s8_ff;
         denp_s9_ff   <= denp_s8_ff;
         d2_s9_ff.neg <= rs_s8_ff[RS_W-1] ^ dneg_s8_ff;
         d2_s9_ff.rs  <= rs_s8_ff;
      end
   end

   fcr_div_pipe #(
      .NUM_W  (NUM2_W),
      .DEN_W  (DEN_W),
      .Q_W    (QUO_W),
      .SIDE_W ($bits(div2_side_type))
   ) u_div_rp (
      .clock    (clock),
      .en       (en),
      .num_in   (num2_s9_ff),
      .den_in   (denp_s9_ff),
      .side_in  (d2_s9_ff),
      .quo_out  (quo2),
      .side_out (d2_out)
   );

   // stage 10: average, halve toward zero, clamp, round to Q1.15
   logic signed [RS_W-1:0] rp;
   logic signed [RS_W:0]   sum_in, hs_in;
   logic [Q20_W-1:0]       rcl_in;
   logic [REFL_W-1:0]      refl_ff;

   assign rp     = d2_out.neg ? -$signed({1'b0, quo2}) : $signed({1'b0, quo2});
   assign sum_in = (RS_W+1)'(d2_out.rs) + (RS_W+1)'(rp);
   assign hs_in  = (sum_in + $signed({{RS_W{1'b0}}, sum_in[RS_W]})) >>> 1;

   always_comb begin
      if (hs_in[RS_W]) begin
         rcl_in = '0;
      end else if (hs_in > $signed((RS_W+1)'(ONE_Q20))) begin
         rcl_in = ONE_Q20;
      end else begin
         rcl_in = Q20_W'(hs_in);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         refl_ff <= REFL_W'(((Q20_W+1)'(rcl_in) + (Q20_W+1)'(16)) >> 5);
      end
   end

   assign refl = refl_ff;

endmodule

// ===== hdl/fresnel_conductor_rgb.sv =====
// Each request passes through 107 register stages, the first loaded when the request is
// accepted, before its response shows on the outputs.
// Throughput: one request per cycle unless the pipe holds; each lane is a fully pipelined
// chain of two root-bit-per-stage square roots and two quotient-bit-per-stage dividers.
// The whole pipe advances together; it holds while a response waits untaken.
// Reset (synchronous, active high) empties the pipe; no clearing pass is needed.
module fresnel_conductor_rgb
   import fcr_pkg::*;
#(
   parameter int CHANNELS = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // cos_inc[15:0], eta_red, eta_green, eta_blue, k_red, k_green, k_blue (16 bits each)
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // refl_red[15:0], refl_green[31:16], refl_blue[47:32]
   output logic [RSP_W-1:0] rsp_tdata
);

   logic                advance;
   logic [LANE_LAT-1:0] vld_ff, vld_in;
   logic [IO_W-1:0]     cos_raw;
   logic [C14_W-1:0]    c14;

   // advance when the output register is empty or is being drained
   assign advance    = ~vld_ff[LANE_LAT-1] | rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = vld_ff[LANE_LAT-1];

   // valid bits travel with the data; a bubble enters when no request is offered
   assign vld_in = {vld_ff[LANE_LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // clamp the cosine to 0..1 once and share it across lanes
   assign cos_raw = req_tdata[IO_W-1:0];
   always_comb begin
      if (cos_raw[IO_W-1]) begin
         c14 = '0;
      end else if (cos_raw > IO_W'(C14_ONE)) begin
         c14 = C14_ONE;
      end else begin
         c14 = cos_raw[C14_W-1:0];
      end
   end

   // one lane per channel; channels not built drive zero
   for (genvar ch = 0; ch < FIELDS; ch++) begin : g_lane
      if (ch < CHANNELS) begin : g_on
         fcr_lane u_lane (
            .clock (clock),
            .en    (advance),
            .c14   (c14),
            .eta   (req_tdata[IO_W*(1+ch) +: IO_W]),
            .k     (req_tdata[IO_W*(1+FIELDS+ch) +: IO_W]),
            .refl  (rsp_tdata[REFL_W*ch +: REFL_W])
         );
      end else begin : g_off
         assign rsp_tdata[REFL_W*ch +: REFL_W] = '0;
      end
   end

endmodule

// ===== hdl/fcr_checker.sv =====
// Port-level checker for the Fresnel conductor block and its bind.
`include "fresnel_conductor_rgb_assert.svh"

module fcr_checker
   import fcr_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   logic refl_in_range;

   assign refl_in_range = (rsp_tdata[15:0] <= REFL_ONE) && (rsp_tdata[31:16] <= REFL_ONE)
                          && (rsp_tdata[47:32] <= REFL_ONE);

   `FCR_ASSERT_IMPL(a_empty_after_reset, $past(reset), !rsp_tvalid)
   `FCR_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `FCR_ASSERT_IMPL(a_stall_blocks_req, rsp_tvalid && !rsp_tready, !req_tready)
   `FCR_ASSERT_IMPL(a_refl_range, rsp_tvalid, refl_in_range)

endmodule

bind fresnel_conductor_rgb fcr_checker u_fcr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
